/* rtl/medt_pkg.sv */
// Package: shared widths, hash constants and types for the mesh edge dedup table.
package medt_pkg;

   localparam int VERT_W   = 16;
   localparam int FACE_W   = 12;
   localparam int CORNER_W = 4;
   localparam int COUNT_W  = 4;
   localparam int EDGE_W   = 12;

   // corner counter stops at MAX_CORNERS-1 on overlong faces
   localparam int MAX_CORNERS = 16;

   localparam logic [COUNT_W-1:0] USE_MAX = 4'd15;

   localparam logic [31:0] HASH_MUL_LO = 32'd2654435761;
   localparam logic [15:0] HASH_MUL_HI = 16'd40503;
   localparam logic [32:0] HASH_ADD    = 33'h0_0000_9E37;

   typedef struct packed {
      logic [VERT_W-1:0]   lo;
      logic [VERT_W-1:0]   hi;
      logic [FACE_W-1:0]   face;
      logic [CORNER_W-1:0] corner;
      logic                last;
   } edge_job_type;

   typedef struct packed {
      logic space;
      logic empty;
   } queue_status_type;

endpackage

/* rtl/medt_ram.sv */
// Generic simple dual-port RAM with registered read.
module medt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/medt_queue.sv */
// Short edge job queue between the front and the back.
module medt_queue import medt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  edge_job_type     push_job,
   input  logic             pop,
   output edge_job_type     head_job,
   output queue_status_type status
);

   localparam int DEPTH = 4;
   localparam int PW    = $clog2(DEPTH);

   edge_job_type     slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    rd_ptr_ff;
   logic [PW:0]      count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop)      count_ff <= count_ff + 1'b1;
         else if (!push && pop) count_ff <= count_ff - 1'b1;
      end
   end

   assign head_job     = slot_ff[rd_ptr_ff];
   assign status.space = count_ff < (PW+1)'(DEPTH);
   assign status.empty = count_ff == '0;

endmodule

/* rtl/medt_front.sv */
// Front: takes face vertices and splits them into ordered edge jobs.
module medt_front import medt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [VERT_W-1:0]  req_vertex_index,
   input  logic               req_last_in_face,
   input  logic               clearing,
   input  queue_status_type   q_status,
   output logic               push,
   output edge_job_type       push_job
);

   logic [VERT_W-1:0]   first_ff;
   logic [VERT_W-1:0]   prev_ff;
   logic [CORNER_W-1:0] corner_ff;
   logic [FACE_W-1:0]   face_ff;
   logic                pend_valid_ff;
   edge_job_type        pend_ff;

   logic         accept;
   edge_job_type mid_job;
   edge_job_type close_job;

   function automatic edge_job_type make_job(input logic [VERT_W-1:0] a,
                                             input logic [VERT_W-1:0] b,
                                             input logic [FACE_W-1:0] face,
                                             input logic [CORNER_W-1:0] corner,
                                             input logic last);
      edge_job_type j;
      j.lo     = (a < b) ? a : b;
      j.hi     = (a < b) ? b : a;
      j.face   = face;
      j.corner = corner;
      j.last   = last;
      return j;
   endfunction

   assign req_stall = pend_valid_ff || !q_status.space || clearing;
   assign accept    = req_valid && !req_stall;

   assign mid_job   = make_job(prev_ff, req_vertex_index, face_ff,
                               corner_ff - 1'b1, !req_last_in_face);
   assign close_job = make_job(req_vertex_index,
                               (corner_ff == '0) ? req_vertex_index : first_ff,
                               face_ff, corner_ff, 1'b1);

   always_comb begin
      push     = 1'b0;
      push_job = mid_job;
      if (pend_valid_ff) begin
         push     = q_status.space;
         push_job = pend_ff;
      end else if (accept) begin
         if (corner_ff != '0) begin
            push = 1'b1;
         end else if (req_last_in_face) begin
            push     = 1'b1;
            push_job = close_job;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ff <= close_job;
      end
      if (reset) begin
         first_ff      <= '0;
         prev_ff       <= '0;
         corner_ff     <= '0;
         face_ff       <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         if (pend_valid_ff && q_status.space) begin
            pend_valid_ff <= 1'b0;
         end
         if (accept) begin
            if (corner_ff == '0) first_ff <= req_vertex_index;
            if (req_last_in_face) begin
               pend_valid_ff <= corner_ff != '0;
               corner_ff     <= '0;
               face_ff       <= face_ff + 1'b1;
            end else begin
               prev_ff <= req_vertex_index;
               if (corner_ff < CORNER_W'(MAX_CORNERS - 1)) corner_ff <= corner_ff + 1'b1;
            end
         end
      end
   end

endmodule

/* rtl/medt_back.sv */
// Back: hashes each edge, probes the key table, inserts or counts, drives results.
module medt_back import medt_pkg::*; #(
   parameter int MAX_EDGES  = 4096,
   parameter int HASH_SLOTS = 8192
) (
   input  logic                clock,
   input  logic                reset,
   input  queue_status_type    q_status,
   input  edge_job_type        head_job,
   output logic                pop,
   output logic                clearing,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [EDGE_W-1:0]   rsp_edge_number,
   output logic                rsp_is_new,
   output logic [FACE_W-1:0]   rsp_face_number,
   output logic [CORNER_W-1:0] rsp_corner_number,
   output logic [VERT_W-1:0]   rsp_vertex_low,
   output logic [VERT_W-1:0]   rsp_vertex_high,
   output logic [COUNT_W-1:0]  rsp_use_count,
   output logic                rsp_table_full,
   output logic                rsp_last_result
);

   localparam int SW  = $clog2(HASH_SLOTS);
   localparam int IDW = $clog2(MAX_EDGES);
   localparam int ECW = $clog2(MAX_EDGES + 1);
   localparam int KW  = 1 + 2 * VERT_W + IDW;

   typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_HASH, ST_IDX, ST_PROBE, ST_EMIT}
      state_type;
   typedef enum logic [1:0] {RES_HIT, RES_NEW, RES_FULL} kind_type;

   state_type          state_ff;
   kind_type           kind_ff;
   edge_job_type       job_ff;
   logic [47:0]        p_lo_ff;
   logic [31:0]        p_hi_ff;
   logic [SW-1:0]      idx_ff;
   logic [SW-1:0]      probes_ff;
   logic [SW-1:0]      clr_ff;
   logic [ECW-1:0]     edge_cnt_ff;
   logic [IDW-1:0]     id_ff;

   logic                rsp_valid_ff;
   logic [EDGE_W-1:0]   rsp_edge_ff;
   logic                rsp_new_ff;
   logic [FACE_W-1:0]   rsp_face_ff;
   logic [CORNER_W-1:0] rsp_corner_ff;
   logic [VERT_W-1:0]   rsp_lo_ff;
   logic [VERT_W-1:0]   rsp_hi_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic                rsp_full_ff;
   logic                rsp_last_ff;

   logic [KW-1:0]      key_q;
   logic               key_wr_en;
   logic [SW-1:0]      key_wr_addr;
   logic [KW-1:0]      key_wr_data;
   logic [SW-1:0]      key_rd_addr;
   logic [COUNT_W-1:0] cnt_q;
   logic               cnt_wr_en;
   logic [IDW-1:0]     cnt_wr_addr;
   logic [COUNT_W-1:0] cnt_wr_data;

   logic               key_valid;
   logic [VERT_W-1:0]  key_lo;
   logic [VERT_W-1:0]  key_hi;
   logic [IDW-1:0]     key_id;
   logic               hit;
   logic               last_probe;
   logic               out_free;
   logic               room;
   logic [IDW-1:0]     id_new;
   logic [COUNT_W-1:0] cnt_next;
   logic [32:0]        hi_term;
   logic [47:0]        h_mix;
   logic [47:0]        h_fold;
   logic [SW-1:0]      hash_idx;
   logic [31:0]        id_wide;

   assign key_valid  = key_q[KW-1];
   assign key_lo     = key_q[KW-2 -: VERT_W];
   assign key_hi     = key_q[KW-2-VERT_W -: VERT_W];
   assign key_id     = key_q[IDW-1:0];
   assign hit        = key_valid && key_lo == job_ff.lo && key_hi == job_ff.hi;
   assign last_probe = probes_ff == SW'(HASH_SLOTS - 1);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign room       = edge_cnt_ff < ECW'(MAX_EDGES);
   assign id_new     = IDW'(edge_cnt_ff);
   assign cnt_next   = (cnt_q < USE_MAX) ? cnt_q + 1'b1 : cnt_q;

   // slot index: fold of the two products, taken modulo the slot count
   assign hi_term  = {1'b0, p_hi_ff} + HASH_ADD;
   assign h_mix    = p_lo_ff ^ {15'b0, hi_term};
   assign h_fold   = h_mix ^ (h_mix >> 15);
   assign hash_idx = h_fold[SW-1:0];

   assign pop      = state_ff == ST_IDLE && !q_status.empty;
   assign clearing = state_ff == ST_CLEAR;

   always_comb begin
      key_rd_addr = idx_ff;
      if (state_ff == ST_IDX) begin
         key_rd_addr = hash_idx;
      end else if (state_ff == ST_PROBE && key_valid && !hit && !last_probe) begin
         key_rd_addr = idx_ff + 1'b1;
      end

      key_wr_en   = 1'b0;
      key_wr_addr = idx_ff;
      key_wr_data = {1'b1, job_ff.lo, job_ff.hi, id_new};
      cnt_wr_en   = 1'b0;
      cnt_wr_addr = id_ff;
      cnt_wr_data = cnt_next;
      if (state_ff == ST_CLEAR) begin
         key_wr_en   = 1'b1;
         key_wr_addr = clr_ff;
         key_wr_data = '0;
      end else if (state_ff == ST_EMIT && out_free) begin
         if (kind_ff == RES_NEW) begin
            key_wr_en   = 1'b1;
            cnt_wr_en   = 1'b1;
            cnt_wr_addr = id_new;
            cnt_wr_data = COUNT_W'(1);
         end else if (kind_ff == RES_HIT) begin
            cnt_wr_en = 1'b1;
         end
      end

      id_wide = (kind_ff == RES_NEW) ? 32'(id_new) : 32'(id_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         edge_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // in ST_EMIT the emit arm owns rsp_valid_ff
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_EMIT) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == SW'(HASH_SLOTS - 1)) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (!q_status.empty) begin
                  job_ff   <= head_job;
                  state_ff <= ST_HASH;
               end
            end
            ST_HASH: begin
               p_lo_ff  <= 48'(job_ff.lo) * 48'(HASH_MUL_LO);
               p_hi_ff  <= 32'(job_ff.hi) * 32'(HASH_MUL_HI);
               state_ff <= ST_IDX;
            end
            ST_IDX: begin
               idx_ff    <= hash_idx;
               probes_ff <= '0;
               state_ff  <= ST_PROBE;
            end
            ST_PROBE: begin
               if (hit) begin
                  kind_ff  <= RES_HIT;
                  id_ff    <= key_id;
                  state_ff <= ST_EMIT;
               end else if (!key_valid) begin
                  kind_ff  <= room ? RES_NEW : RES_FULL;
                  state_ff <= ST_EMIT;
               end else if (last_probe) begin
                  kind_ff  <= RES_FULL;
                  state_ff <= ST_EMIT;
               end else begin
                  idx_ff    <= idx_ff + 1'b1;
                  probes_ff <= probes_ff + 1'b1;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_face_ff   <= job_ff.face;
                  rsp_corner_ff <= job_ff.corner;
                  rsp_lo_ff     <= job_ff.lo;
                  rsp_hi_ff     <= job_ff.hi;
                  rsp_last_ff   <= job_ff.last;
                  rsp_new_ff    <= kind_ff == RES_NEW;
                  rsp_full_ff   <= kind_ff == RES_FULL;
                  case (kind_ff)
                     RES_NEW: begin
                        rsp_edge_ff  <= id_wide[EDGE_W-1:0];
                        rsp_count_ff <= COUNT_W'(1);
                        edge_cnt_ff  <= edge_cnt_ff + 1'b1;
                     end
                     RES_HIT: begin
                        rsp_edge_ff  <= id_wide[EDGE_W-1:0];
                        rsp_count_ff <= cnt_next;
                     end
                     default: begin
                        rsp_edge_ff  <= '0;
                        rsp_count_ff <= '0;
                     end
                  endcase
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   medt_ram #(.WIDTH(KW), .DEPTH(HASH_SLOTS)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (key_wr_addr),
      .wr_data (key_wr_data),
      .rd_addr (key_rd_addr),
      .rd_data (key_q)
   );

   medt_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_EDGES)) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_addr (key_id),
      .rd_data (cnt_q)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_edge_number   = rsp_edge_ff;
   assign rsp_is_new        = rsp_new_ff;
   assign rsp_face_number   = rsp_face_ff;
   assign rsp_corner_number = rsp_corner_ff;
   assign rsp_vertex_low    = rsp_lo_ff;
   assign rsp_vertex_high   = rsp_hi_ff;
   assign rsp_use_count     = rsp_count_ff;
   assign rsp_table_full    = rsp_full_ff;
   assign rsp_last_result   = rsp_last_ff;

endmodule

/* rtl/mesh_edge_dedup_table.sv */
// Top level of the mesh edge dedup table: front, edge job queue and probe back end.
//
//   channel | direction | handshake             | payload
//   req_    | in        | req_valid / req_stall | vertex_index, last_in_face
//   rsp_    | out       | rsp_valid / rsp_stall | edge id, flags, face, corner, vertices, count
//
// Each edge passes through the back end states in order (queue pop, hash multiply, fold,
// one key slot probe, emit), repeating the probe step for each extra linear probe; the
// registered key RAM read paces the probe loop. A vertex that opens a face but does not close
// it yields no edge; any other yields its middle edge, the closing edge or both. After reset a
// clearing pass writes every key slot with req_stall high. A stall on rsp_ holds the output
// register; the front keeps taking vertices until the four-entry edge job queue fills.
module mesh_edge_dedup_table import medt_pkg::*; #(
   parameter int MAX_EDGES  = 4096,
   parameter int HASH_SLOTS = 8192
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [VERT_W-1:0]   req_vertex_index,
   input  logic                req_last_in_face,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [EDGE_W-1:0]   rsp_edge_number,
   output logic                rsp_is_new,
   output logic [FACE_W-1:0]   rsp_face_number,
   output logic [CORNER_W-1:0] rsp_corner_number,
   output logic [VERT_W-1:0]   rsp_vertex_low,
   output logic [VERT_W-1:0]   rsp_vertex_high,
   output logic [COUNT_W-1:0]  rsp_use_count,
   output logic                rsp_table_full,
   output logic                rsp_last_result
);

   queue_status_type q_status;
   edge_job_type     push_job;
   edge_job_type     head_job;
   logic             push;
   logic             pop;
   logic             clearing;

   // front: vertex to edge jobs, middle edge ahead of the closing edge
   medt_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_vertex_index (req_vertex_index),
      .req_last_in_face (req_last_in_face),
      .clearing         (clearing),
      .q_status         (q_status),
      .push             (push),
      .push_job         (push_job)
   );

   medt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (q_status)
   );

   // back: hash, probe, insert or bump the use count, one edge at a time
   medt_back #(.MAX_EDGES(MAX_EDGES), .HASH_SLOTS(HASH_SLOTS)) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_status          (q_status),
      .head_job          (head_job),
      .pop               (pop),
      .clearing          (clearing),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_edge_number   (rsp_edge_number),
      .rsp_is_new        (rsp_is_new),
      .rsp_face_number   (rsp_face_number),
      .rsp_corner_number (rsp_corner_number),
      .rsp_vertex_low    (rsp_vertex_low),
      .rsp_vertex_high   (rsp_vertex_high),
      .rsp_use_count     (rsp_use_count),
      .rsp_table_full    (rsp_table_full),
      .rsp_last_result   (rsp_last_result)
   );

endmodule

/* sim/edge_checker.sv */
// Edge table checker: watches both channels, predicts edge results and compares them.
`timescale 1ns / 100ps

module edge_checker import medt_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [VERT_W-1:0]   req_vertex_index,
   input  logic                req_last_in_face,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [EDGE_W-1:0]   rsp_edge_number,
   input  logic                rsp_is_new,
   input  logic [FACE_W-1:0]   rsp_face_number,
   input  logic [CORNER_W-1:0] rsp_corner_number,
   input  logic [VERT_W-1:0]   rsp_vertex_low,
   input  logic [VERT_W-1:0]   rsp_vertex_high,
   input  logic [COUNT_W-1:0]  rsp_use_count,
   input  logic                rsp_table_full,
   input  logic                rsp_last_result,
   output int                  fail_count,
   output int                  pending_edges
);
   localparam int N_EDGES = 4096;
   localparam int N_SLOTS = 8192;

   typedef struct packed {
      logic [EDGE_W-1:0]   id;
      logic                fresh;
      logic [FACE_W-1:0]   face;
      logic [CORNER_W-1:0] corner;
      logic [VERT_W-1:0]   lo;
      logic [VERT_W-1:0]   hi;
      logic [COUNT_W-1:0]  uses;
      logic                full;
      logic                last;
   } edge_use_type;

   edge_use_type edge_queue[$];

   logic [VERT_W-1:0]   face_first, prev_vert;
   logic [CORNER_W-1:0] corner_cnt;
   logic [FACE_W-1:0]   face_cnt;
   int                  edges_issued;
   bit                  slot_used[N_SLOTS];
   logic [VERT_W-1:0]   slot_lo[N_SLOTS], slot_hi[N_SLOTS];
   int                  slot_edge[N_SLOTS];
   logic [COUNT_W-1:0]  uses_of[N_EDGES];

   initial begin
      fail_count = 0;
      pending_edges = 0;
   end

   function automatic int slot_hash(logic [VERT_W-1:0] lo, logic [VERT_W-1:0] hi);
      logic [63:0] h;
      h = (64'(lo) * 64'd2654435761) ^ (64'(hi) * 64'd40503 + 64'h9E37);
      h = h ^ (h >> 15);
      return int'(h % N_SLOTS);
   endfunction

   task automatic lookup_edge(logic [VERT_W-1:0] a, logic [VERT_W-1:0] b,
                              logic [CORNER_W-1:0] c, logic last);
      edge_use_type e;
      int idx, n;
      bit hit, hole;
      e = '0;
      e.lo = (a < b) ? a : b;
      e.hi = (a < b) ? b : a;
      e.face = face_cnt;
      e.corner = c;
      e.last = last;
      idx = slot_hash(e.lo, e.hi);
      hit = 0;
      hole = 0;
      for (n = 0; n < N_SLOTS; n++) begin
         if (!slot_used[idx]) begin
            hole = 1;
            break;
         end
         if (slot_lo[idx] == e.lo && slot_hi[idx] == e.hi) begin
            hit = 1;
            break;
         end
         idx = (idx + 1) % N_SLOTS;
      end
      if (hit) begin
         e.id = EDGE_W'(slot_edge[idx]);
         if (uses_of[e.id] < USE_MAX) uses_of[e.id]++;
         e.uses = uses_of[e.id];
      end else if (hole && edges_issued < N_EDGES) begin
         slot_used[idx] = 1;
         slot_lo[idx] = e.lo;
         slot_hi[idx] = e.hi;
         slot_edge[idx] = edges_issued;
         e.id = EDGE_W'(edges_issued);
         uses_of[edges_issued] = COUNT_W'(1);
         edges_issued++;
         e.uses = COUNT_W'(1);
         e.fresh = 1'b1;
      end else begin
         e.full = 1'b1;
      end
      edge_queue.push_back(e);
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      edge_use_type w;
      if (reset) begin
         face_first = '0;
         prev_vert = '0;
         corner_cnt = '0;
         face_cnt = '0;
         edges_issued = 0;
         foreach (slot_used[i]) slot_used[i] = 0;
      end else begin
         // result side first: a transfer in this cycle cannot depend on this edge's input
         if (rsp_valid && !rsp_stall) begin
            if (edge_queue.size() == 0) begin
               report_mismatch("unexpected result, edge", rsp_edge_number, -1);
            end else begin
               w = edge_queue.pop_front();
               if (rsp_edge_number !== w.id) report_mismatch("edge_number", rsp_edge_number, w.id);
               if (rsp_is_new !== w.fresh) report_mismatch("is_new", rsp_is_new, w.fresh);
               if (rsp_face_number !== w.face) report_mismatch("face_number", rsp_face_number, w.face);
               if (rsp_corner_number !== w.corner)
                  report_mismatch("corner_number", rsp_corner_number, w.corner);
               if (rsp_vertex_low !== w.lo) report_mismatch("vertex_low", rsp_vertex_low, w.lo);
               if (rsp_vertex_high !== w.hi) report_mismatch("vertex_high", rsp_vertex_high, w.hi);
               if (rsp_use_count !== w.uses) report_mismatch("use_count", rsp_use_count, w.uses);
               if (rsp_table_full !== w.full) report_mismatch("table_full", rsp_table_full, w.full);
               if (rsp_last_result !== w.last)
                  report_mismatch("last_result", rsp_last_result, w.last);
            end
         end
         if (req_valid && !req_stall) begin
            if (corner_cnt == 0) face_first = req_vertex_index;
            else lookup_edge(prev_vert, req_vertex_index, corner_cnt - 1'b1, !req_last_in_face);
            if (req_last_in_face) begin
               lookup_edge(req_vertex_index, face_first, corner_cnt, 1'b1);
               corner_cnt = '0;
               face_cnt = face_cnt + 1'b1;
            end else begin
               prev_vert = req_vertex_index;
               if (corner_cnt < MAX_CORNERS - 1) corner_cnt = corner_cnt + 1'b1;
            end
         end
      end
      pending_edges = edge_queue.size();
   end
endmodule

/* sim/testbench.sv */
// Testbench top: drives vertex streams into the dedup table and gives the verdict.
`timescale 1ns / 100ps

module testbench;
   import medt_pkg::*;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [VERT_W-1:0]   req_vertex_index;
   logic                req_last_in_face;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [EDGE_W-1:0]   rsp_edge_number;
   logic                rsp_is_new;
   logic [FACE_W-1:0]   rsp_face_number;
   logic [CORNER_W-1:0] rsp_corner_number;
   logic [VERT_W-1:0]   rsp_vertex_low;
   logic [VERT_W-1:0]   rsp_vertex_high;
   logic [COUNT_W-1:0]  rsp_use_count;
   logic                rsp_table_full;
   logic                rsp_last_result;
   int                  fail_count;
   int                  pending_edges;

   // idling switches off for the last stretch of the run
   bit quiet_tail = 0;
   // vertex pool, small so that edges repeat and use counts climb
   logic [VERT_W-1:0] pool[64];

   mesh_edge_dedup_table u_top (.*);

   edge_checker u_check (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // time budget for the clear pass after reset plus ~1800 vertices with probes and stalls
   initial begin
      #20ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // result-side stall: random bursts, none in the quiet tail
   initial begin
      rsp_stall = 0;
      forever begin
         @(negedge clock);
         if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1;
            repeat ($urandom_range(1, 14)) @(negedge clock);
            rsp_stall <= 0;
         end
      end
   end

   // one vertex transfer; an optional idle burst goes ahead of it
   task automatic send_vertex(logic [VERT_W-1:0] v, logic last);
      if (!quiet_tail && $urandom_range(0, 7) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_valid <= 1;
      req_vertex_index <= v;
      req_last_in_face <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_face(int corners, bit from_pool);
      for (int k = 0; k < corners; k++)
         send_vertex(from_pool ? pool[$urandom_range(0, 63)] : VERT_W'($urandom),
                     k == corners - 1);
   endtask

   initial begin
      int sent, n;
      reset = 1;
      req_valid = 0;
      req_vertex_index = '0;
      req_last_in_face = 0;
      foreach (pool[i]) pool[i] = VERT_W'($urandom);
      pool[0] = '0;
      pool[1] = '1;
      repeat (10) @(negedge clock);
      reset = 0;

      // directed: one-vertex face, extremes, a shared edge, an overlong face
      send_vertex('0, 1);
      send_vertex('1, 1);
      send_vertex('0, 0);
      send_vertex('1, 1);
      send_vertex('1, 0);
      send_vertex('0, 1);
      send_vertex(16'h00FF, 0);
      send_vertex(16'hFF00, 0);
      send_vertex(16'h5555, 1);
      for (int k = 0; k < 19; k++) send_vertex(VERT_W'(k * 16'h0AAB), k == 18);

      // random faces: mostly reused vertices, some fresh ones, a few long faces
      sent = 0;
      while (sent < 1570) begin
         if (sent > 1300) quiet_tail = 1;
         case ($urandom_range(0, 9))
            0:       n = $urandom_range(1, 2);
            1:       n = $urandom_range(15, 20);
            default: n = $urandom_range(3, 6);
         endcase
         send_face(n, $urandom_range(0, 3) != 0);
         sent += n;
      end
      // keep the face counter moving: many one-vertex faces
      for (int k = 0; k < 200; k++) send_vertex(pool[$urandom_range(0, 63)], 1);
      req_valid <= 0;

      while (pending_edges != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
